// File: rtl/core/qcpm_pkg.sv
// shared types, constants and register indexes of the cascaded pid motor mixer
package qcpm_pkg;

  localparam int FracBits  = 4;
  localparam int GainW     = 24;
  localparam int NumGains  = 8;
  localparam int IdxW      = 3;
  localparam int SensW     = 16;
  localparam int StickW    = 12;
  localparam int ModeW     = 2;
  localparam int MotorW    = 13;
  localparam int QuotW     = 14;
  localparam int DivInW    = 20;
  localparam int AngleLim  = 20 << FracBits;
  localparam int RateLim   = 90 << FracBits;

  typedef enum logic [IdxW-1:0] {
    RegAngleP  = 3'd0,
    RegAngleI  = 3'd1,
    RegRateP   = 3'd2,
    RegRateIP  = 3'd3,
    RegRateIR  = 3'd4,
    RegRateDP  = 3'd5,
    RegRateDR  = 3'd6,
    RegYaw     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeSport  = 2'd1,
    ModeCal    = 2'd2,
    ModeSpare  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ANG,
    S_ATRUNC,
    S_RATE,
    S_MIX
  } state_t;

  typedef logic [GainW-1:0] gain_t;

  localparam gain_t GainReset [NumGains] = '{
    24'd3984589, 24'd0, 24'd1468006, 24'd524,
    24'd2412, 24'd52429, 24'd83886, 24'd3670016
  };

endpackage

// File: rtl/core/qcpm_in_if.sv
// input channel: one control tick word
interface qcpm_in_if
  import qcpm_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ModeW-1:0]         mode;
  logic signed [SensW-1:0]  tilt_x;
  logic signed [SensW-1:0]  tilt_y;
  logic signed [SensW-1:0]  rate_x;
  logic signed [SensW-1:0]  rate_y;
  logic signed [SensW-1:0]  rate_z;
  logic [StickW-1:0]        stick_roll;
  logic [StickW-1:0]        stick_pitch;
  logic [StickW-1:0]        stick_throttle;
  logic [StickW-1:0]        stick_yaw;

  modport source (output valid, mode, tilt_x, tilt_y, rate_x, rate_y, rate_z,
                  stick_roll, stick_pitch, stick_throttle, stick_yaw, input ready);
  modport sink   (input valid, mode, tilt_x, tilt_y, rate_x, rate_y, rate_z,
                  stick_roll, stick_pitch, stick_throttle, stick_yaw, output ready);
endinterface

// File: rtl/core/qcpm_out_if.sv
// output channel: one motor command word
interface qcpm_out_if
  import qcpm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MotorW-1:0] motor_one;
  logic [MotorW-1:0] motor_two;
  logic [MotorW-1:0] motor_three;
  logic [MotorW-1:0] motor_four;
  logic              cutoff;

  modport source (output valid, motor_one, motor_two, motor_three, motor_four, cutoff,
                  input ready);
  modport sink   (input valid, motor_one, motor_two, motor_three, motor_four, cutoff,
                  output ready);
endinterface

// File: rtl/core/qcpm_div83.sv
// bit-serial restoring divider by 83, one quotient bit a cycle
module qcpm_div83
  import qcpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DivInW-1:0] dividend,
  output logic [QuotW-1:0]  quot,
  output logic              done
);

  localparam int CntW = $clog2(DivInW + 1);

  logic [DivInW-1:0] num;
  logic [DivInW-1:0] q;
  logic [6:0]        rem;
  logic [CntW-1:0]   cnt;
  logic [7:0]        trial;
  logic              fits;

  assign trial = {rem, num[DivInW-1]};
  assign fits  = trial >= 8'd83;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CntW'(DivInW);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      q   <= '0;
    end else if (cnt != '0) begin
      num <= {num[DivInW-2:0], 1'b0};
      rem <= fits ? 7'(trial - 8'd83) : trial[6:0];
      q   <= {q[DivInW-2:0], fits};
    end
  end

  assign quot = q[QuotW-1:0];

endmodule

// File: rtl/core/quad_cascaded_pid_mixer_unit.sv
// top level: cascaded angle and rate pid with quad motor mixer
// One tick word in, one motor word out. After acceptance a word passes the setup state,
// shift-and-add over the angle loop gains, a truncation state, shift-and-add over the
// rate loop gains and the mixing state, which loads the result into the output register
// once that register is free; only then is the next word taken. The serial multipliers
// walk one gain bit per cycle, most significant first, so the 24 bit gain width sets the
// length of each loop; the throttle map divider by 83 runs alongside the angle loop.
// A finished word sits in the output register while the next tick is accepted. Gains
// are written through cfg_wen/cfg_index/cfg_data; the user must do so only while idle,
// as the block itself does not enforce it.
module quad_cascaded_pid_mixer_unit
  import qcpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [IdxW-1:0]  cfg_index,
  input  logic [GainW-1:0] cfg_data,
  qcpm_in_if.sink          in_ch,
  qcpm_out_if.source       out_ch
);

  localparam int CntW = $clog2(GainW);
  localparam int AccA = 44;   // angle loop accumulator
  localparam int AccR = 54;   // rate and yaw accumulators

  // ---------------------------------------------------------------------------
  // helper arithmetic
  // ---------------------------------------------------------------------------
  function automatic logic [8:0] div10(input logic [StickW-1:0] ch);
    logic [27:0] prod;
    begin
      prod  = 28'(ch) * 28'(16'd52429);
      div10 = prod[27:19];
    end
  endfunction

  function automatic logic [10:0] div3(input logic [StickW-1:0] ch);
    logic [27:0] prod;
    begin
      prod = 28'(ch) * 28'(16'd43691);
      div3 = prod[27:17];
    end
  endfunction

  // truncate toward zero, 20 fraction bits dropped
  function automatic logic signed [23:0] ang_trunc(input logic signed [AccA-1:0] x);
    logic [AccA-1:0] mag;
    logic [AccA-1:0] sh;
    begin
      mag       = x[AccA-1] ? AccA'(-x) : AccA'(x);
      sh        = mag >> 20;
      ang_trunc = x[AccA-1] ? -24'(sh) : 24'(sh);
    end
  endfunction

  // truncate mix term to whole units and clamp to +-225
  function automatic logic signed [8:0] mix_term(input logic signed [AccR-1:0] x);
    logic [AccR-1:0] mag;
    logic [AccR-1:0] sh;
    logic [8:0]      lim;
    begin
      mag = x[AccR-1] ? AccR'(-x) : AccR'(x);
      sh  = mag >> (FracBits + 20);
      lim = (sh > AccR'(225)) ? 9'd225 : sh[8:0];
      mix_term = x[AccR-1] ? -lim : lim;
    end
  endfunction

  function automatic logic [MotorW-1:0] motor_val(input logic [QuotW-1:0] q,
                                                  input logic signed [8:0] m);
    logic signed [15:0] d;
    begin
      d = $signed({2'b00, q}) - 16'(m);
      if (d < 16'sd1000) begin
        motor_val = 13'd1000;
      end else if (d > 16'sd3000) begin
        motor_val = 13'd3000;
      end else begin
        motor_val = d[MotorW-1:0];
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // gain registers
  // ---------------------------------------------------------------------------
  gain_t gain [NumGains];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GainReset;
    end else if (cfg_wen) begin
      gain[cfg_index] <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  state_t          state;
  state_t          state_next;
  logic [CntW-1:0] cnt;
  logic            accept;
  logic            out_load;
  logic            out_valid;
  logic            last_bit;

  assign accept   = in_ch.valid && in_ch.ready;
  assign last_bit = cnt == CntW'(GainW - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP:   state_next = S_ANG;
      S_ANG: begin
        if (last_bit) begin
          state_next = S_ATRUNC;
        end
      end
      S_ATRUNC: state_next = S_RATE;
      S_RATE: begin
        if (last_bit) begin
          state_next = S_MIX;
        end
      end
      S_MIX: begin
        // hand over once the output register is free
        if (!out_valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if ((state == S_ANG || state == S_RATE) && !last_bit) begin
      cnt <= cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // captured tick word
  // ---------------------------------------------------------------------------
  logic [ModeW-1:0]        mode;
  logic signed [SensW-1:0] ax, ay, gx, gy, gz;
  logic [StickW-1:0]       ch1, ch2, ch3, ch4;
  logic                    calib;
  logic                    normal;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode <= in_ch.mode;
      ax   <= in_ch.tilt_x;
      ay   <= in_ch.tilt_y;
      gx   <= in_ch.rate_x;
      gy   <= in_ch.rate_y;
      gz   <= in_ch.rate_z;
      ch1  <= in_ch.stick_roll;
      ch2  <= in_ch.stick_pitch;
      ch3  <= in_ch.stick_throttle;
      ch4  <= in_ch.stick_yaw;
    end
  end

  // spare mode code behaves as calibration
  assign calib  = mode == ModeCal || mode == ModeSpare;
  assign normal = mode == ModeNormal;

  // ---------------------------------------------------------------------------
  // setpoints and integrals, worked out in the setup cycle
  // ---------------------------------------------------------------------------
  logic signed [10:0] sp_n, sr_n;
  logic signed [11:0] sp_s, sr_s, sy_s;
  logic signed [17:0] ex_c, ey_c, yerr_c;
  logic signed [16:0] rsx_sum, rsy_sum;
  logic signed [16:0] asx_sum, asy_sum;

  logic signed [9:0]  asx, asy;     // angle integrals
  logic signed [11:0] rsx, rsy;     // rate integrals
  logic signed [17:0] ex, ey, yerr;
  logic signed [16:0] spt_p, spt_r;

  assign sp_n = $signed({2'b00, div10(ch2)}) - 11'sd150;
  assign sr_n = $signed({2'b00, div10(ch1)}) - 11'sd150;
  assign sp_s = $signed({1'b0, div3(ch2)}) - 12'sd500;
  assign sr_s = $signed({1'b0, div3(ch1)}) - 12'sd500;
  assign sy_s = $signed({1'b0, div3(ch4)}) - 12'sd501;

  assign ex_c   = (18'(sp_n) <<< FracBits) - 18'(ax);
  assign ey_c   = (18'(sr_n) <<< FracBits) - 18'(ay);
  assign yerr_c = (18'(sy_s) <<< FracBits) - 18'(gz);

  assign rsx_sum = 17'(rsx) + 17'(gx);
  assign rsy_sum = 17'(rsy) + 17'(gy);
  assign asx_sum = 17'(asx) + 17'(ax);
  assign asy_sum = 17'(asy) + 17'(ay);

  function automatic logic signed [16:0] sat(input logic signed [16:0] v, input int lim);
    logic signed [16:0] hi;
    begin
      hi  = 17'(lim);
      sat = (v > hi) ? hi : ((v < -hi) ? -hi : v);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      asx <= '0;
      asy <= '0;
      rsx <= '0;
      rsy <= '0;
    end else if (state == S_PREP && !calib) begin
      rsx <= 12'(sat(rsx_sum, RateLim));
      rsy <= 12'(sat(rsy_sum, RateLim));
      if (normal) begin
        asx <= 10'(sat(asx_sum, AngleLim));
        asy <= 10'(sat(asy_sum, AngleLim));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      ex    <= ex_c;
      ey    <= ey_c;
      yerr  <= yerr_c;
      spt_p <= 17'(sp_s) <<< FracBits;
      spt_r <= 17'(sr_s) <<< FracBits;
    end
  end

  // ---------------------------------------------------------------------------
  // serial multipliers, one gain bit per cycle, msb first
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] bsel;
  logic kap_b, kai_b, krp_b, kip_b, kir_b, kdp_b, kdr_b, ky_b;

  assign bsel  = CntW'(GainW - 1) - cnt;
  assign kap_b = gain[RegAngleP][bsel];
  assign kai_b = gain[RegAngleI][bsel];
  assign krp_b = gain[RegRateP][bsel];
  assign kip_b = gain[RegRateIP][bsel];
  assign kir_b = gain[RegRateIR][bsel];
  assign kdp_b = gain[RegRateDP][bsel];
  assign kdr_b = gain[RegRateDR][bsel];
  assign ky_b  = gain[RegYaw][bsel];

  logic signed [AccA-1:0] aacc_x, aacc_y;
  logic signed [AccR-1:0] pacc, racc, yacc;
  logic signed [24:0]     p1, r1;
  logic signed [15:0]     p2, r2;
  logic signed [23:0]     ap_c, ar_c;

  assign ap_c = ang_trunc(aacc_x);
  assign ar_c = ang_trunc(aacc_y);

  always_ff @(posedge clk) begin
    case (state)
      S_PREP: begin
        aacc_x <= '0;
        aacc_y <= '0;
        pacc   <= '0;
        racc   <= '0;
        yacc   <= '0;
      end
      S_ANG: begin
        // outer loop: error times p gain plus integral times i gain
        aacc_x <= (aacc_x <<< 1) + (kap_b ? AccA'(ex) : '0) + (kai_b ? AccA'(asx) : '0);
        aacc_y <= (aacc_y <<< 1) + (kap_b ? AccA'(ey) : '0) + (kai_b ? AccA'(asy) : '0);
      end
      S_ATRUNC: begin
        // the angle loop output becomes the rate setpoint in normal mode
        p1 <= normal ? 25'(ap_c) - 25'(gy) : 25'(spt_p) - 25'(gy);
        r1 <= normal ? 25'(ar_c) + 25'(gx) : 25'(spt_r) + 25'(gx);
        p2 <= normal ? gy : '0;
        r2 <= normal ? gx : '0;
      end
      S_RATE: begin
        pacc <= (pacc <<< 1) + (krp_b ? AccR'(p1) : '0)
                - (kdp_b ? AccR'(p2) : '0) - (kip_b ? AccR'(rsy) : '0);
        racc <= (racc <<< 1) + (krp_b ? AccR'(r1) : '0)
                + (kdr_b ? AccR'(r2) : '0) + (kir_b ? AccR'(rsx) : '0);
        yacc <= (yacc <<< 1) + (ky_b ? AccR'(yerr) : '0);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // throttle map: max(200*ch3 - 135000, 0) / 83
  // ---------------------------------------------------------------------------
  logic signed [21:0]  thr_lin;
  logic [DivInW-1:0]   thr_pos;
  logic [QuotW-1:0]    quot;
  logic                div_done;

  assign thr_lin = $signed({2'b00, 20'(ch3) * 20'd200}) - 22'sd135000;
  assign thr_pos = thr_lin[21] ? '0 : thr_lin[DivInW-1:0];

  qcpm_div83 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_PREP),
    .dividend (thr_pos),
    .quot     (quot),
    .done     (div_done)
  );

  // ---------------------------------------------------------------------------
  // mixer and output register
  // ---------------------------------------------------------------------------
  logic signed [AccR-1:0] mix0, mix1, mix2, mix3;
  logic [MotorW-1:0]      m_one, m_two, m_three, m_four, cal_val;
  logic                   cut;

  assign mix0 = -racc - pacc + yacc;
  assign mix1 =  racc + pacc + yacc;
  assign mix2 =  racc - pacc - yacc;
  assign mix3 = -racc + pacc - yacc;

  assign cut     = !calib && ch3 >= 12'd1890;
  assign cal_val = (quot > QuotW'(8191)) ? 13'd8191 : quot[MotorW-1:0];

  always_comb begin
    if (calib) begin
      m_one   = cal_val;
      m_two   = cal_val;
      m_three = cal_val;
      m_four  = cal_val;
    end else if (cut) begin
      m_one   = 13'd2900;
      m_two   = 13'd2900;
      m_three = 13'd2900;
      m_four  = 13'd2900;
    end else begin
      m_one   = motor_val(quot, mix_term(mix0));
      m_two   = motor_val(quot, mix_term(mix1));
      m_three = motor_val(quot, mix_term(mix2));
      m_four  = motor_val(quot, mix_term(mix3));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.motor_one   <= m_one;
      out_ch.motor_two   <= m_two;
      out_ch.motor_three <= m_three;
      out_ch.motor_four  <= m_four;
      out_ch.cutoff      <= cut;
    end
  end

  assign out_ch.valid = out_valid;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_rate_sat : assert property (@(posedge clk) disable iff (rst)
    rsx <= 12'sd1440 && rsx >= -12'sd1440 && rsy <= 12'sd1440 && rsy >= -12'sd1440)
    else $error("rate integral beyond its limit");

  a_angle_sat : assert property (@(posedge clk) disable iff (rst)
    asx <= 10'sd320 && asx >= -10'sd320 && asy <= 10'sd320 && asy >= -10'sd320)
    else $error("angle integral beyond its limit");

  a_div_ready : assert property (@(posedge clk) disable iff (rst)
    state == S_MIX |-> div_done)
    else $error("throttle divider not finished at mixing");

  a_cut_level : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.cutoff |-> out_ch.motor_one == 13'd2900
      && out_ch.motor_four == 13'd2900)
    else $error("cutoff word without forced motor level");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_valid || out_ch.ready)
    else $error("output word overwritten before being taken");

endmodule
